>>> src/lls_pkg.sv
// shared types, codes and constants for the locking lru sector cache
package lls_pkg;

  localparam int COORD_W    = 26;
  localparam int KEY_W      = 2 * COORD_W;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int SLOTS_W    = 5;
  localparam int LOCK_W     = 16;
  localparam int STAMP_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_W;

  localparam int DEF_CACHE_SLOTS = 16;

  localparam logic [COORD_W-1:0] COORD_MAX     = 26'h3FF_FFFF;
  localparam logic [SLOTS_W-1:0] SLOTS_RST     = 5'd16;
  localparam logic [LOCK_W-1:0]  LOCK_SAT      = 16'hFFFF;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOADED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EVICTED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALL_LOCKED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNLOCK_MISS = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd2;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] sector_x;
    logic [COORD_W-1:0] sector_y;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [COORD_W-1:0]    victim_x;
    logic [COORD_W-1:0]    victim_y;
  } rsp_t;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_SCAN,
    CTL_WAIT,
    CTL_COMMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic scan_en;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ctl_sts_t;

endpackage

>>> src/lls_ctrl.sv
// controller state machine sequencing request load, slot scan and commit
module lls_ctrl
  import lls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd,
  output logic     busy
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CTL_IDLE: begin
        if (start) state_nxt = CTL_SCAN;
      end
      CTL_SCAN: begin
        if (sts.scan_last) state_nxt = CTL_WAIT;
      end
      CTL_WAIT:   state_nxt = CTL_COMMIT;
      CTL_COMMIT: state_nxt = CTL_IDLE;
      default:    state_nxt = CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      CTL_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      CTL_SCAN:   cmd.scan_en = 1'b1;
      CTL_WAIT:   cmd = '0;
      CTL_COMMIT: cmd.commit = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

>>> src/lls_dp.sv
// datapath: config registers, slot memories, scan accumulators and commit logic
module lls_dp
  import lls_pkg::*;
#(
  parameter int CACHE_SLOTS = DEF_CACHE_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output ctl_sts_t              sts,
  input  req_t                  in_req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output rsp_t                  out_rsp
);

  localparam int SW = $clog2(CACHE_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(CACHE_SLOTS - 1);

  function automatic logic [SLOT_OUT_W-1:0] slot4(input logic [SW-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[SLOT_OUT_W-1:0];
  endfunction

  logic [COORD_W-1:0] limit_x_r, limit_y_r;
  logic [SLOTS_W-1:0] slots_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_x_r <= COORD_MAX;
      limit_y_r <= COORD_MAX;
      slots_r   <= SLOTS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LIMIT_X:      limit_x_r <= cfg_data;
        CFG_LIMIT_Y:      limit_y_r <= cfg_data;
        CFG_SLOTS_IN_USE: slots_r   <= cfg_data[SLOTS_W-1:0];
        default:          ;
      endcase
    end
  end

  req_t req_r;
  logic [KEY_W-1:0] req_key;
  assign req_key = {req_r.sector_y, req_r.sector_x};

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_req;
  end

  logic [KEY_W-1:0]   key_mem   [CACHE_SLOTS];
  logic [LOCK_W-1:0]  lock_mem  [CACHE_SLOTS];
  logic [STAMP_W-1:0] stamp_mem [CACHE_SLOTS];

  logic [SW-1:0]      rd_idx_r;
  logic [KEY_W-1:0]   key_q;
  logic [LOCK_W-1:0]  lock_q;
  logic [STAMP_W-1:0] stamp_q;

  logic               we_key, we_lock, we_stamp;
  logic [SW-1:0]      wr_idx;
  logic [LOCK_W-1:0]  wr_lock;
  logic [STAMP_W-1:0] wr_stamp;

  always_ff @(posedge clk) begin
    if (we_key)   key_mem[wr_idx]   <= req_key;
    if (we_lock)  lock_mem[wr_idx]  <= wr_lock;
    if (we_stamp) stamp_mem[wr_idx] <= wr_stamp;
    key_q   <= key_mem[rd_idx_r];
    lock_q  <= lock_mem[rd_idx_r];
    stamp_q <= stamp_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (cmd.load) begin
      rd_idx_r <= '0;
    end else if (cmd.scan_en) begin
      rd_idx_r <= rd_idx_r + SW'(1);
    end
  end

  assign sts.scan_last = (rd_idx_r == LAST_IDX);

  logic [CACHE_SLOTS-1:0] valid_r, valid_nxt;
  logic                   eval_v_r;
  logic [SW-1:0]          idx_q_r;
  logic                   valid_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_v_r <= 1'b0;
    end else begin
      eval_v_r <= cmd.scan_en;
    end
    idx_q_r   <= rd_idx_r;
    valid_q_r <= valid_r[rd_idx_r];
  end

  logic               in_scope;
  logic               hit_found_r, free_found_r, old_found_r;
  logic [SW-1:0]      hit_idx_r, free_idx_r, old_idx_r;
  logic [LOCK_W-1:0]  hit_locks_r;
  logic [STAMP_W-1:0] old_stamp_r;
  logic [KEY_W-1:0]   old_key_r;

  assign in_scope = 32'(idx_q_r) < 32'(slots_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      old_found_r  <= 1'b0;
    end else if (eval_v_r) begin
      if (valid_q_r && key_q == req_key && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= idx_q_r;
        hit_locks_r <= lock_q;
      end
      if (in_scope && !valid_q_r && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_q_r;
      end
      if (in_scope && valid_q_r && lock_q == '0 &&
          (!old_found_r || stamp_q < old_stamp_r)) begin
        old_found_r <= 1'b1;
        old_idx_r   <= idx_q_r;
        old_stamp_r <= stamp_q;
        old_key_r   <= key_q;
      end
    end
  end

  logic [SLOTS_W-1:0] vc_r, vc_nxt;
  logic [STAMP_W-1:0] serial_r, serial_nxt;
  logic               out_valid_r, out_valid_nxt;
  rsp_t               rsp_r, rsp_nxt;
  logic               in_range, full;
  logic [SW-1:0]      fill_idx;

  assign in_range = (req_r.sector_x < limit_x_r) && (req_r.sector_y < limit_y_r);
  assign full = (32'(vc_r) >= 32'(slots_r)) || (32'(vc_r) >= 32'(CACHE_SLOTS));

  always_comb begin
    out_valid_nxt = 1'b0;
    rsp_nxt       = rsp_r;
    valid_nxt     = valid_r;
    vc_nxt        = vc_r;
    serial_nxt    = serial_r;
    we_key        = 1'b0;
    we_lock       = 1'b0;
    we_stamp      = 1'b0;
    wr_idx        = hit_idx_r;
    wr_lock       = hit_locks_r;
    wr_stamp      = serial_r + STAMP_W'(1);
    fill_idx      = free_idx_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      rsp_nxt       = '0;
      if (req_r.op == OP_UNLOCK) begin
        if (hit_found_r) begin
          rsp_nxt.status = ST_HIT;
          rsp_nxt.slot   = slot4(hit_idx_r);
          we_lock        = 1'b1;
          if (hit_locks_r != '0) wr_lock = hit_locks_r - LOCK_W'(1);
        end else begin
          rsp_nxt.status = ST_UNLOCK_MISS;
        end
      end else if (!in_range) begin
        rsp_nxt.status = ST_RANGE;
      end else begin
        serial_nxt = serial_r + STAMP_W'(1);
        if (hit_found_r) begin
          rsp_nxt.status = ST_HIT;
          rsp_nxt.slot   = slot4(hit_idx_r);
          we_lock        = 1'b1;
          we_stamp       = 1'b1;
          if (hit_locks_r != LOCK_SAT) wr_lock = hit_locks_r + LOCK_W'(1);
        end else if (full) begin
          if (!old_found_r) begin
            rsp_nxt.status = ST_ALL_LOCKED;
          end else begin
            if (free_found_r && free_idx_r < old_idx_r) fill_idx = free_idx_r;
            else fill_idx = old_idx_r;
            rsp_nxt.status   = ST_EVICTED;
            rsp_nxt.slot     = slot4(fill_idx);
            rsp_nxt.victim_x = old_key_r[COORD_W-1:0];
            rsp_nxt.victim_y = old_key_r[KEY_W-1:COORD_W];
            valid_nxt[old_idx_r] = 1'b0;
            valid_nxt[fill_idx]  = 1'b1;
            wr_idx   = fill_idx;
            wr_lock  = LOCK_W'(1);
            we_key   = 1'b1;
            we_lock  = 1'b1;
            we_stamp = 1'b1;
          end
        end else if (!free_found_r) begin
          rsp_nxt.status = ST_ALL_LOCKED;
        end else begin
          rsp_nxt.status      = ST_LOADED;
          rsp_nxt.slot        = slot4(free_idx_r);
          valid_nxt[free_idx_r] = 1'b1;
          vc_nxt   = vc_r + SLOTS_W'(1);
          wr_idx   = free_idx_r;
          wr_lock  = LOCK_W'(1);
          we_key   = 1'b1;
          we_lock  = 1'b1;
          we_stamp = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      vc_r        <= '0;
      serial_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      vc_r        <= vc_nxt;
      serial_r    <= serial_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rsp_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule

>>> src/locking_lru_sector_cache_top.sv
// top level of the locking lru sector cache: controller plus datapath
//
//  channel  ports                            transfer
//  request  start, busy, in_req              start && !busy at a rising edge
//  result   out_valid, out_rsp               one-cycle strobe, always taken
//  config   cfg_we, cfg_idx, cfg_data        cfg_we at a rising edge
//
// a request runs from accept through the slot scan, a wait state and commit to the next accept:
// the scan reads one slot per cycle from the key, lock and stamp memories
// the result strobe comes the cycle after commit; a new request may be taken then
// synchronous active-low reset clears valid bits at once, no clearing pass
// the receiver cannot stall; results are never held off
module locking_lru_sector_cache_top
  import lls_pkg::*;
#(
  parameter int CACHE_SLOTS = DEF_CACHE_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  in_req,
  output logic                  out_valid,
  output rsp_t                  out_rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lls_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lls_dp #(
    .CACHE_SLOTS (CACHE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted request");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a request in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != ST_EVICTED |->
      out_rsp.victim_x == '0 && out_rsp.victim_y == '0)
    else $error("victim key reported without eviction");
`endif

endmodule

>>> sim/locking_lru_sector_cache_top_tb.sv
// self-checking testbench for the locking lru sector cache top level
`timescale 1ns / 100ps

module locking_lru_sector_cache_top_tb;
  import lls_pkg::*;

  localparam int CACHE_SLOTS = DEF_CACHE_SLOTS;
  localparam int REQ_CYCLES  = CACHE_SLOTS + 3;
  localparam int POOL_SIZE   = 20;
  localparam int PHASE_ITEMS = 100;
  localparam int MAX_REPORTS = 10;

  class sector_cache_scoreboard #(int SLOTS = 16);
    logic [COORD_W-1:0]  limit_x;
    logic [COORD_W-1:0]  limit_y;
    logic [SLOTS_W-1:0]  slots_in_use;
    bit                  slot_valid [SLOTS];
    logic [KEY_W-1:0]    slot_key   [SLOTS];
    logic [LOCK_W-1:0]   slot_locks [SLOTS];
    logic [STAMP_W-1:0]  slot_stamp [SLOTS];
    logic [SLOTS_W-1:0]  valid_count;
    logic [STAMP_W-1:0]  lock_serial;
    rsp_t                pending_rsp [$];
    int                  errors;

    function new();
      limit_x      = COORD_MAX;
      limit_y      = COORD_MAX;
      slots_in_use = SLOTS_RST;
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
        slot_locks[i] = '0;
        slot_stamp[i] = '0;
      end
      valid_count = '0;
      lock_serial = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LIMIT_X:      limit_x = data;
        CFG_LIMIT_Y:      limit_y = data;
        CFG_SLOTS_IN_USE: slots_in_use = data[SLOTS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(req_t r);
      rsp_t             e;
      logic [KEY_W-1:0] k;
      int               n;
      int               hit;
      int               pick;
      e    = '0;
      k    = {r.sector_y, r.sector_x};
      n    = (slots_in_use < SLOTS) ? int'(slots_in_use) : SLOTS;
      hit  = -1;
      pick = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && slot_valid[i] && slot_key[i] == k) hit = i;
      end
      if (r.op == OP_UNLOCK) begin
        if (hit < 0) begin
          e.status = ST_UNLOCK_MISS;
        end else begin
          if (slot_locks[hit] != '0) slot_locks[hit] = slot_locks[hit] - 1'b1;
          e.status = ST_HIT;
          e.slot   = SLOT_OUT_W'(hit);
        end
      end else if (r.sector_x >= limit_x || r.sector_y >= limit_y) begin
        e.status = ST_RANGE;
      end else begin
        lock_serial = lock_serial + 1'b1;
        if (hit >= 0) begin
          if (slot_locks[hit] != LOCK_SAT) slot_locks[hit] = slot_locks[hit] + 1'b1;
          slot_stamp[hit] = lock_serial;
          e.status = ST_HIT;
          e.slot   = SLOT_OUT_W'(hit);
        end else begin
          e.status = ST_LOADED;
          // full cache: evict the least recently locked unlocked slot
          if (int'(valid_count) >= n) begin
            for (int i = 0; i < n; i++) begin
              if (slot_valid[i] && slot_locks[i] == '0 &&
                  (pick < 0 || slot_stamp[i] < slot_stamp[pick])) pick = i;
            end
            if (pick < 0) begin
              e.status = ST_ALL_LOCKED;
            end else begin
              e.victim_x = slot_key[pick][COORD_W-1:0];
              e.victim_y = slot_key[pick][KEY_W-1:COORD_W];
              slot_valid[pick] = 1'b0;
              if (valid_count != '0) valid_count = valid_count - 1'b1;
              e.status = ST_EVICTED;
            end
          end
          if (e.status != ST_ALL_LOCKED) begin
            pick = -1;
            for (int i = 0; i < n; i++) begin
              if (pick < 0 && !slot_valid[i]) pick = i;
            end
            if (pick < 0) begin
              e        = '0;
              e.status = ST_ALL_LOCKED;
            end else begin
              slot_valid[pick] = 1'b1;
              slot_key[pick]   = k;
              slot_locks[pick] = LOCK_W'(1);
              slot_stamp[pick] = lock_serial;
              valid_count      = valid_count + 1'b1;
              e.slot           = SLOT_OUT_W'(pick);
            end
          end
        end
      end
      pending_rsp.push_back(e);
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected result: status %0d slot %0d victim (%0h,%0h)",
                   a.status, a.slot, a.victim_x, a.victim_y);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (a.status !== e.status || a.slot !== e.slot ||
            a.victim_x !== e.victim_x || a.victim_y !== e.victim_y) begin
          if (errors < MAX_REPORTS)
            $display("mismatch: exp st %0d sl %0d v (%0h,%0h) got st %0d sl %0d v (%0h,%0h)",
                     e.status, e.slot, e.victim_x, e.victim_y,
                     a.status, a.slot, a.victim_x, a.victim_y);
          errors++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  req_t                  in_req;
  logic                  out_valid;
  rsp_t                  out_rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  sector_cache_scoreboard #(CACHE_SLOTS) sb;
  int                 idle_pct;
  int                 phase_idle_pct [4] = '{0, 72, 0, 29};
  logic [COORD_W-1:0] pool_x [POOL_SIZE];
  logic [COORD_W-1:0] pool_y [POOL_SIZE];

  locking_lru_sector_cache_top #(.CACHE_SLOTS(CACHE_SLOTS)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_request(in_req);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_rsp);
  end

  function automatic logic [COORD_W-1:0] coord_below(input logic [COORD_W-1:0] lim);
    if (lim != '0 && $urandom_range(9) != 0) return COORD_W'($urandom_range(lim - 1, 0));
    return COORD_W'($urandom);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   k;
    int   s;
    r.op = ($urandom_range(99) < 45) ? OP_UNLOCK : OP_LOCK;
    k = $urandom_range(POOL_SIZE - 1);
    r.sector_x = pool_x[k];
    r.sector_y = pool_y[k];
    if ($urandom_range(9) == 0) begin
      r.sector_x = coord_below(sb.limit_x);
      r.sector_y = coord_below(sb.limit_y);
    end else if (r.op == OP_UNLOCK && $urandom_range(9) < 7) begin
      // unlock something actually held so slots free up for eviction
      s = $urandom_range(CACHE_SLOTS - 1);
      if (sb.slot_valid[s]) {r.sector_y, r.sector_x} = sb.slot_key[s];
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (REQ_CYCLES + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic configure(input logic [COORD_W-1:0] lx, input logic [COORD_W-1:0] ly,
                           input logic [SLOTS_W-1:0] n);
    drain();
    write_reg(CFG_LIMIT_X, lx);
    write_reg(CFG_LIMIT_Y, ly);
    write_reg(CFG_SLOTS_IN_USE, CFG_DATA_W'(n));
    cfg_we <= 1'b0;
  endtask

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    sb       = new();
    idle_pct = 0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_req   = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests
    configure(COORD_MAX, COORD_MAX, SLOTS_RST);
    send_request(req_t'{OP_LOCK, 26'd0, 26'd0});
    send_request(req_t'{OP_LOCK, COORD_MAX - 1'b1, COORD_MAX - 1'b1});
    send_request(req_t'{OP_LOCK, COORD_MAX, 26'd0});
    send_request(req_t'{OP_LOCK, 26'd0, COORD_MAX});
    send_request(req_t'{OP_LOCK, 26'd0, 26'd0});
    repeat (3) send_request(req_t'{OP_UNLOCK, 26'd0, 26'd0});
    send_request(req_t'{OP_UNLOCK, 26'd5, 26'd5});
    send_request(req_t'{OP_UNLOCK, COORD_MAX, COORD_MAX});
    configure(COORD_MAX, COORD_MAX, 5'd3);
    send_request(req_t'{OP_LOCK, 26'd1, 26'd1});
    send_request(req_t'{OP_LOCK, 26'd2, 26'd2});
    send_request(req_t'{OP_UNLOCK, 26'd1, 26'd1});
    send_request(req_t'{OP_UNLOCK, COORD_MAX - 1'b1, COORD_MAX - 1'b1});
    send_request(req_t'{OP_LOCK, 26'd3, 26'd3});
    configure(COORD_MAX, COORD_MAX, 5'd0);
    send_request(req_t'{OP_LOCK, 26'd3, 26'd3});
    send_request(req_t'{OP_LOCK, 26'd9, 26'd9});
    configure(26'd0, COORD_MAX, 5'd31);
    send_request(req_t'{OP_LOCK, 26'd0, 26'd0});
    configure(COORD_MAX, 26'd0, 5'd31);
    send_request(req_t'{OP_LOCK, 26'd0, 26'd0});
    send_request(req_t'{OP_UNLOCK, 26'd3, 26'd3});

    // random phases with different settings and sender idling
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: configure(COORD_MAX, COORD_MAX, SLOTS_RST);
        1: configure(COORD_W'($urandom_range(COORD_MAX, 1)), COORD_MAX, 5'd5);
        2: configure(COORD_MAX, COORD_W'($urandom_range(COORD_MAX, 1)), 5'd31);
        default: configure(COORD_W'($urandom_range(COORD_MAX, 1)),
                           COORD_W'($urandom_range(COORD_MAX, 1)), 5'd2);
      endcase
      idle_pct = phase_idle_pct[p];
      for (int i = 0; i < POOL_SIZE; i++) begin
        pool_x[i] = coord_below(sb.limit_x);
        pool_y[i] = coord_below(sb.limit_y);
      end
      repeat (PHASE_ITEMS) send_request(random_request());
    end

    drain();
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
